// ----- rtl/core/dadd_pkg.sv -----
`default_nettype none
package dadd_pkg;

	localparam int unsigned DAYS_WIDTH_DEF = 16;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W = 5;
	localparam int unsigned YEAR_W = 14;
	localparam int unsigned YEAR_CYCLE = 400;
	localparam int unsigned YR400_W = $clog2(YEAR_CYCLE);
	localparam int unsigned REDUCE_STEPS = 6;
	localparam int unsigned REDUCE_CNT_W = $clog2(REDUCE_STEPS);

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	localparam logic [YR400_W-1:0] CENT_1 = 9'd100;
	localparam logic [YR400_W-1:0] CENT_2 = 9'd200;
	localparam logic [YR400_W-1:0] CENT_3 = 9'd300;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                 over;
		logic [MONTH_W-1:0]   month_next;
		logic                 year_inc;
	} step_t;

	function automatic logic leap_from_cycle(input logic [YR400_W-1:0] yr400);
		logic div4;
		logic cent;
		div4 = (yr400[1:0] == 2'b00);
		cent = (yr400 == CENT_1) || (yr400 == CENT_2) || (yr400 == CENT_3);
		return div4 && !cent;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			MON_FEB: begin
				len = leap ? 5'd29 : 5'd28;
			end
			default: begin
				len = (m inside {MON_APR, MON_JUN, MON_SEP, MON_NOV}) ? 5'd30 : 5'd31;
			end
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/dadd_mod400.sv -----
`default_nettype none
module dadd_mod400
	import dadd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [YEAR_W-1:0]  year,
	output logic                    done,
	output logic [YR400_W-1:0]      rem
);

	logic [YEAR_W-1:0]       rem_q;
	logic [REDUCE_CNT_W-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [YEAR_W-1:0]       sub;
	logic                    ge;

	// Restoring reduction: one shifted multiple of the cycle length per clock.
	assign sub = YEAR_W'(YEAR_CYCLE) << cnt_q;
	assign ge  = (rem_q >= sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= REDUCE_CNT_W'(REDUCE_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= year;
		end else if (busy_q && ge) begin
			rem_q <= rem_q - sub;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[YR400_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/core/dadd_month_unit.sv -----
`default_nettype none
module dadd_month_unit
	import dadd_pkg::*;
#(
	parameter int unsigned DAYS_WIDTH = DAYS_WIDTH_DEF
) (
	input  wire logic [MONTH_W-1:0]    month,
	input  wire logic [YR400_W-1:0]    yr400,
	input  wire logic [DAYS_WIDTH:0]   day,
	output step_t                      step,
	output logic [DAYS_WIDTH:0]        day_next
);

	logic [DAY_W-1:0]      len;
	logic [DAYS_WIDTH:0]   len_ext;

	assign len     = month_len(month, leap_from_cycle(yr400));
	assign len_ext = (DAYS_WIDTH+1)'(len);

	always_comb begin
		step.over     = (day > len_ext);
		step.year_inc = (month == MON_DEC);
		step.month_next = step.year_inc ? MON_JAN : month + 1'b1;
		day_next      = day - len_ext;
	end

endmodule
`default_nettype wire

// ----- rtl/core/calendar_date_add_days_core.sv -----
// A null date or a bad month goes straight to the result; otherwise a
// six-step reduction of the year modulo 400 runs first, then the shared
// subtract/compare unit handles one month per cycle. One item at a time: the
// next transfer is accepted in the cycle after the result is loaded.
// Reset clears the sequencer and the output valid; the datapath is not reset.
`default_nettype none
module calendar_date_add_days_core
	import dadd_pkg::*;
#(
	parameter int unsigned DAYS_WIDTH = DAYS_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   date_present,
	input  wire logic [MONTH_W-1:0]     start_month,
	input  wire logic [DAY_W-1:0]       start_day,
	input  wire logic [YEAR_W-1:0]      start_year,
	input  wire logic [DAYS_WIDTH-1:0]  days_to_add,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        result_present,
	output logic [MONTH_W-1:0]          result_month,
	output logic [DAY_W-1:0]            result_day,
	output logic [YEAR_W-1:0]           result_year,
	output logic                        bad_month
);

	state_t                state_q, state_d;
	logic                  present_q;
	logic                  bad_q;
	logic [MONTH_W-1:0]    month_q;
	logic [DAYS_WIDTH:0]   day_q;
	logic [YEAR_W-1:0]     year_q;
	logic [YR400_W-1:0]    yr400_q;
	logic                  out_valid_q;

	logic                  accept;
	logic                  month_ok;
	logic                  red_start;
	logic                  red_done;
	logic [YR400_W-1:0]    red_rem;
	step_t                 step;
	logic [DAYS_WIDTH:0]   day_next;
	logic                  do_step;
	logic                  out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign month_ok  = (start_month >= MON_JAN) && (start_month <= MON_DEC);
	assign red_start = accept && date_present && month_ok;

	dadd_mod400 u_mod400 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.year   (start_year),
		.done   (red_done),
		.rem    (red_rem)
	);

	dadd_month_unit #(
		.DAYS_WIDTH (DAYS_WIDTH)
	) u_month (
		.month    (month_q),
		.yr400    (yr400_q),
		.day      (day_q),
		.step     (step),
		.day_next (day_next)
	);

	always_comb begin
		state_d  = state_q;
		do_step  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = red_start ? ST_REDUCE : ST_FINISH;
				end
			end
			ST_REDUCE: begin
				if (red_done) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (step.over) begin
					do_step = 1'b1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			present_q <= date_present;
			bad_q     <= date_present && !month_ok;
			month_q   <= start_month;
			year_q    <= start_year;
			if (red_start) begin
				day_q <= (DAYS_WIDTH+1)'(start_day) + (DAYS_WIDTH+1)'(days_to_add);
			end else begin
				day_q <= (DAYS_WIDTH+1)'(start_day);
			end
		end else if (state_q == ST_REDUCE && red_done) begin
			yr400_q <= red_rem;
		end else if (do_step) begin
			day_q   <= day_next;
			month_q <= step.month_next;
			if (step.year_inc) begin
				year_q <= year_q + 1'b1;
				if (year_q == '1 || yr400_q == YR400_W'(YEAR_CYCLE - 1)) begin
					yr400_q <= '0;
				end else begin
					yr400_q <= yr400_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_present <= present_q;
			result_month   <= month_q;
			result_day     <= day_q[DAY_W-1:0];
			result_year    <= year_q;
			bad_month      <= bad_q;
		end
	end

	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (month_q >= MON_JAN) && (month_q <= MON_DEC))
		else $error("month left the valid range while stepping");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (yr400_q < YR400_W'(YEAR_CYCLE))
			&& (yr400_q[1:0] == year_q[1:0]))
		else $error("year cycle position disagrees with the year");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) && !step.over |=> (state_q == ST_FINISH)
			&& (day_q[DAYS_WIDTH:DAY_W] == '0))
		else $error("stepping stopped with a day beyond the month");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_load && bad_q |-> present_q)
		else $error("bad month flagged on a null date");

endmodule
`default_nettype wire
